>>> hw/rtl/bbf_pkg.sv
// Package for the blocked Bloom filter: sizes, Murmur constants, state type.
// Used by bbf_hash and blocked_bloom_filter; no dependencies.
package bbf_pkg;
  localparam int MaxHashes = 7;
  localparam int NumBlocks = 4096;
  localparam int BlockBits = 512;
  localparam int NumSeeds = 8;
  localparam int BlkW = $clog2(NumBlocks);
  localparam int PosW = $clog2(BlockBits);
  localparam int NbW = 13;
  localparam int HCntW = 3;

  localparam logic [31:0] MmC1 = 32'hcc9e2d51;
  localparam logic [31:0] MmC2 = 32'h1b873593;
  localparam logic [31:0] MmAdd = 32'he6546b64;
  localparam logic [31:0] FmC1 = 32'h85ebca6b;
  localparam logic [31:0] FmC2 = 32'hc2b2ae35;

  localparam logic [2:0] RegNumHashes = 3'd0;
  localparam logic [2:0] RegBlocks = 3'd1;
  localparam logic [2:0] RegSeed0 = 3'd2;
  localparam logic [2:0] RegSeed3 = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SC1, ST_SC2, ST_MIX, ST_FM1, ST_FM2, ST_FM3,
    ST_MOD, ST_RD, ST_RMW, ST_WR, ST_CLR
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction
endpackage

>>> hw/rtl/bbf_hash.sv
// Eight side-by-side Murmur3 running hashes with a shared multiplier chain.
// Depends on bbf_pkg. A word is scrambled in SC1 and SC2 and mixed in MIX; finalization runs in FM1, FM2 and FM3.
module bbf_hash (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [3:0][63:0]            seeds,
  input  logic [31:0]                 word,
  input  logic                        full,
  input  logic [2:0]                  nbytes,
  input  bbf_pkg::state_t             state,
  output logic [bbf_pkg::NumSeeds-1:0][31:0] fin
);
  logic [31:0] k;
  logic [31:0] klen;
  logic [bbf_pkg::NumSeeds-1:0][31:0] h;
  logic [bbf_pkg::NumSeeds-1:0][31:0] h_next;
  logic [31:0] masked;
  logic [bbf_pkg::NumSeeds-1:0][31:0] f;

  // Keep all four bytes on a full word, drop unused bytes on a short tail
  always_comb begin
    masked = word;
    if (!full) begin
      unique case (nbytes)
        3'd1: masked = {24'd0, word[7:0]};
        3'd2: masked = {16'd0, word[15:0]};
        3'd3: masked = {8'd0, word[23:0]};
        default: masked = word;
      endcase
    end
  end

  // Scramble in two registered multiply steps, then mix all lanes
  always_ff @(posedge clk) begin
    if (state == bbf_pkg::ST_SC1) k <= masked * bbf_pkg::MmC1;
    else if (state == bbf_pkg::ST_SC2) k <= bbf_pkg::rotl(k, 15) * bbf_pkg::MmC2;
  end

  always_comb begin
    for (int i = 0; i < bbf_pkg::NumSeeds; i++) begin
      if (full) h_next[i] = bbf_pkg::rotl(h[i] ^ k, 13) * 32'd5 + bbf_pkg::MmAdd;
      else if (nbytes != 3'd0) h_next[i] = h[i] ^ k;
      else h_next[i] = h[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      klen <= '0;
    end else if (load) begin
      klen <= '0;
    end else if (state == bbf_pkg::ST_MIX) begin
      klen <= klen + (full ? 32'd4 : {29'd0, nbytes});
    end
  end

  // Load lane 2k from the low half of seed pair k, lane 2k+1 from the high half
  always_ff @(posedge clk) begin
    if (load) begin
      h <= seeds;
    end else if (state == bbf_pkg::ST_MIX) begin
      h <= h_next;
    end
  end

  // Finalize mix across three registered stages, the first two of them multiplies
  always_ff @(posedge clk) begin
    for (int i = 0; i < bbf_pkg::NumSeeds; i++) begin
      if (state == bbf_pkg::ST_FM1) begin
        f[i] <= ((h[i] ^ klen) ^ ((h[i] ^ klen) >> 16)) * bbf_pkg::FmC1;
      end else if (state == bbf_pkg::ST_FM2) begin
        f[i] <= (f[i] ^ (f[i] >> 13)) * bbf_pkg::FmC2;
      end else if (state == bbf_pkg::ST_FM3) begin
        f[i] <= f[i] ^ (f[i] >> 16);
      end
    end
  end
  assign fin = f;
endmodule

>>> hw/rtl/blocked_bloom_filter.sv
// Top level of the blocked Bloom filter: control, block memory, result.
// Depends on bbf_pkg and bbf_hash.
// A key word that is not the last goes through two scramble multiplies, the
// lane mix and the idle state before the next request is taken. The last
// word goes through the same scramble and mix, then finalization, a bit-serial
// modulo of hash 0 by the clamped block count (32 steps), and a block read,
// modify and write, with done high in the cycle busy falls. After reset a
// clearing pass zeroes the block memory, during which busy is high. present
// and done_kind are registered with done; the receiver cannot stall.
module blocked_bloom_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [31:0] key_word,
  input  logic [2:0]  word_bytes,
  input  logic        last_word,
  output logic        done,
  output logic        done_kind,
  output logic        present,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  bbf_pkg::state_t state, state_next;
  logic [bbf_pkg::HCntW-1:0] bit_hashes;
  logic [bbf_pkg::NbW-1:0] blocks;
  logic [3:0][63:0] seeds;
  logic key_started;
  logic kind_r, last_r, full_r;
  logic [31:0] word_r;
  logic [2:0] nb_r;
  logic [bbf_pkg::NumSeeds-1:0][31:0] fin;
  logic [5:0] cnt;
  logic [bbf_pkg::NbW:0] rem;
  logic [31:0] quo_src;
  logic [bbf_pkg::BlkW-1:0] blk, clr_addr;
  logic [bbf_pkg::BlockBits-1:0] mem [bbf_pkg::NumBlocks];
  logic [bbf_pkg::BlockBits-1:0] rdata, mask;
  logic [2:0] nh_eff;
  logic [bbf_pkg::NbW-1:0] nb_eff;
  logic [bbf_pkg::NbW:0] rem_sh;
  logic accept;

  assign accept = start && !busy;
  assign busy = (state != bbf_pkg::ST_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_hashes <= 3'd3;
      blocks <= bbf_pkg::NbW'(bbf_pkg::NumBlocks);
      seeds <= '0;
    end else if (cfg_we) begin
      if (cfg_index == bbf_pkg::RegNumHashes) bit_hashes <= cfg_data[2:0];
      else if (cfg_index == bbf_pkg::RegBlocks) blocks <= cfg_data[bbf_pkg::NbW-1:0];
      else if (cfg_index >= bbf_pkg::RegSeed0 && cfg_index <= bbf_pkg::RegSeed3)
        seeds[2'(cfg_index - bbf_pkg::RegSeed0)] <= cfg_data;
    end
  end

  assign nh_eff = (bit_hashes > 3'(bbf_pkg::MaxHashes)) ? 3'(bbf_pkg::MaxHashes) : bit_hashes;
  always_comb begin
    nb_eff = blocks;
    if (blocks == '0) nb_eff = 13'd1;
    if (blocks > 13'(bbf_pkg::NumBlocks)) nb_eff = 13'(bbf_pkg::NumBlocks);
  end

  // Hold the request
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind;
      last_r <= last_word;
      word_r <= key_word;
      full_r <= !last_word || word_bytes >= 3'd4;
      nb_r <= (word_bytes >= 3'd4) ? 3'd4 : word_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) key_started <= 1'b0;
    else if (accept) key_started <= !last_word;
  end

  bbf_hash u_hash (
    .clk(clk), .rst(rst), .load(accept && !key_started), .seeds(seeds),
    .word(word_r), .full(full_r), .nbytes(nb_r), .state(state), .fin(fin)
  );

  // Restoring modulo, one quotient bit a cycle
  assign rem_sh = {rem[bbf_pkg::NbW-1:0], quo_src[31]};
  always_ff @(posedge clk) begin
    if (state == bbf_pkg::ST_FM3) begin
      rem <= '0;
    end else if (state == bbf_pkg::ST_MOD) begin
      rem <= (rem_sh >= {1'b0, nb_eff}) ? rem_sh - {1'b0, nb_eff} : rem_sh;
    end
  end
  always_ff @(posedge clk) begin
    if (state == bbf_pkg::ST_FM3) quo_src <= fin[0] ^ (fin[0] >> 16);
    else if (state == bbf_pkg::ST_MOD) quo_src <= quo_src << 1;
  end
  assign blk = rem[bbf_pkg::BlkW-1:0];

  always_comb begin
    mask = '0;
    for (int i = 1; i <= bbf_pkg::MaxHashes; i++)
      if (3'(i) <= nh_eff) mask[fin[i][bbf_pkg::PosW-1:0]] = 1'b1;
  end

  // Block memory: clear pass, read, write back on add
  always_ff @(posedge clk) begin
    if (state == bbf_pkg::ST_CLR) mem[clr_addr] <= '0;
    else if (state == bbf_pkg::ST_WR && !kind_r) mem[blk] <= rdata | mask;
    if (state == bbf_pkg::ST_RD) rdata <= mem[blk];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (state == bbf_pkg::ST_CLR) clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (state == bbf_pkg::ST_FM3) cnt <= '0;
    else if (state == bbf_pkg::ST_MOD) cnt <= cnt + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bbf_pkg::ST_CLR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bbf_pkg::ST_IDLE: if (accept) state_next = bbf_pkg::ST_SC1;
      bbf_pkg::ST_SC1: state_next = bbf_pkg::ST_SC2;
      bbf_pkg::ST_SC2: state_next = bbf_pkg::ST_MIX;
      bbf_pkg::ST_MIX: state_next = last_r ? bbf_pkg::ST_FM1 : bbf_pkg::ST_IDLE;
      bbf_pkg::ST_FM1: state_next = bbf_pkg::ST_FM2;
      bbf_pkg::ST_FM2: state_next = bbf_pkg::ST_FM3;
      bbf_pkg::ST_FM3: state_next = bbf_pkg::ST_MOD;
      bbf_pkg::ST_MOD: if (cnt == 6'd31) state_next = bbf_pkg::ST_RD;
      bbf_pkg::ST_RD: state_next = bbf_pkg::ST_RMW;
      bbf_pkg::ST_RMW: state_next = bbf_pkg::ST_WR;
      bbf_pkg::ST_WR: state_next = bbf_pkg::ST_IDLE;
      bbf_pkg::ST_CLR: if (&clr_addr) state_next = bbf_pkg::ST_IDLE;
      default: state_next = bbf_pkg::ST_IDLE;
    endcase
  end

  // Drive the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (state == bbf_pkg::ST_WR);
  end
  always_ff @(posedge clk) begin
    if (state == bbf_pkg::ST_WR) begin
      done_kind <= kind_r;
      present <= kind_r && ((rdata & mask) == mask);
    end
  end

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_add_absent: assert property (@(posedge clk) disable iff (rst) done && !done_kind |-> !present)
    else $error("present set on add");
  a_busy_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted without busy");
`endif
endmodule

>>> test/tb_blocked_bloom_filter.sv
// Testbench for blocked_bloom_filter: streamed keys hashed, added and queried.
// Depends on bbf_pkg and the RTL; predicts each answer with its own filter model.
module tb_blocked_bloom_filter;

  typedef struct packed {
    logic        kind;
    logic [31:0] key_word;
    logic [2:0]  word_bytes;
    logic        last_word;
  } word_req_t;

  typedef struct packed {
    logic done_kind;
    logic present;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        kind = 1'b0;
  logic [31:0] key_word = '0;
  logic [2:0]  word_bytes = '0;
  logic        last_word = 1'b0;
  logic        done;
  logic        done_kind;
  logic        present;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  blocked_bloom_filter dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .key_word(key_word), .word_bytes(word_bytes), .last_word(last_word),
    .done(done), .done_kind(done_kind), .present(present),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow filter state
  logic [bbf_pkg::BlockBits-1:0] filter_bits [bbf_pkg::NumBlocks];
  logic [31:0] lane_hash [bbf_pkg::NumSeeds];
  logic [31:0] key_len;
  logic        in_key;
  logic [2:0]  hash_count;
  logic [12:0] block_count;
  logic [63:0] seed_pairs [4];

  word_req_t pending_words [$];
  answer_t   expected_answers [$];
  int errors = 0;
  int keys_sent = 0;
  int answers_seen = 0;
  int queries_hit = 0;
  bit stim_done = 0;
  bit hold_off = 0;
  int idle_pct = 35;

  function automatic logic [31:0] rot32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mm_scramble(input logic [31:0] k);
    logic [31:0] t;
    t = k * 32'hcc9e2d51;
    t = rot32(t, 15);
    return t * 32'h1b873593;
  endfunction

  function automatic logic [31:0] mm_fmix(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * 32'h85ebca6b;
    t = t ^ (t >> 13);
    t = t * 32'hc2b2ae35;
    return t ^ (t >> 16);
  endfunction

  // Advance the shadow filter by one word; push an answer on the last word.
  task automatic hash_word(input word_req_t w);
    logic [31:0] k, blk, pos;
    int nh, nb, nbytes;
    bit all_set;
    if (!in_key) begin
      for (int i = 0; i < bbf_pkg::NumSeeds; i++)
        lane_hash[i] = (i & 1) ? seed_pairs[i >> 1][63:32] : seed_pairs[i >> 1][31:0];
      key_len = 0;
      in_key = 1;
    end
    nbytes = w.word_bytes;
    if (!w.last_word || nbytes >= 4) begin
      k = mm_scramble(w.key_word);
      for (int i = 0; i < bbf_pkg::NumSeeds; i++)
        lane_hash[i] = rot32(lane_hash[i] ^ k, 13) * 32'd5 + 32'he6546b64;
      key_len += 4;
    end else if (nbytes > 0) begin
      k = mm_scramble(w.key_word & (32'hffffffff >> (32 - 8 * nbytes)));
      for (int i = 0; i < bbf_pkg::NumSeeds; i++) lane_hash[i] ^= k;
      key_len += nbytes;
    end
    if (w.last_word) begin
      nh = (hash_count > bbf_pkg::MaxHashes) ? bbf_pkg::MaxHashes : hash_count;
      nb = block_count;
      if (nb == 0) nb = 1;
      if (nb > bbf_pkg::NumBlocks) nb = bbf_pkg::NumBlocks;
      blk = mm_fmix(lane_hash[0] ^ key_len) % nb;
      all_set = 1;
      for (int i = 1; i <= nh; i++) begin
        pos = mm_fmix(lane_hash[i] ^ key_len) % bbf_pkg::BlockBits;
        if (w.kind == 1'b0) filter_bits[blk][pos] = 1'b1;
        else if (!filter_bits[blk][pos]) all_set = 0;
      end
      expected_answers.push_back('{done_kind: w.kind, present: w.kind && all_set});
      in_key = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Driver: present the head request, pop it when accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        hash_word(pending_words.pop_front());
        keys_sent++;
      end
      if (!hold_off && pending_words.size() > 0 && !(start && !busy && pending_words.size() == 0)
          && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        {kind, key_word, word_bytes, last_word} <= pending_words[0];
      end else if (start && !busy) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each strobed answer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      answers_seen++;
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected answer, queue depth", 0, 1);
      end else begin
        answer_t want;
        want = expected_answers.pop_front();
        if (done_kind !== want.done_kind) report_mismatch("done_kind", done_kind, want.done_kind);
        if (present !== want.present) report_mismatch("present", present, want.present);
        if (want.done_kind && want.present) queries_hit++;
      end
    end
  end

  task automatic wait_drained(input int tail);
    while (pending_words.size() > 0 || start || expected_answers.size() > 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bbf_pkg::RegNumHashes: hash_count = val[2:0];
      bbf_pkg::RegBlocks: block_count = val[12:0];
      default: seed_pairs[2'(idx - bbf_pkg::RegSeed0)] = val;
    endcase
  endtask

  task automatic queue_key(input logic k, input int nwords, input logic [2:0] tailbytes);
    word_req_t w;
    for (int i = 0; i < nwords; i++) begin
      w.kind = 1'($urandom_range(1));
      w.key_word = $urandom;
      w.word_bytes = 3'($urandom_range(7));
      w.last_word = (i == nwords - 1);
      if (w.last_word) begin
        w.kind = k;
        w.word_bytes = tailbytes;
      end
      pending_words.push_back(w);
    end
  endtask

  // Pick a key from a small pool so queries often hit added keys.
  word_req_t pool [16][$];
  task automatic queue_pool_key(input logic k);
    int p;
    p = $urandom_range(15);
    if (pool[p].size() == 0) begin
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        word_req_t w;
        w.key_word = $urandom;
        w.word_bytes = (i == n - 1) ? 3'($urandom_range(7)) : 3'd4;
        w.last_word = (i == n - 1);
        w.kind = 1'b0;
        pool[p].push_back(w);
      end
    end
    for (int i = 0; i < pool[p].size(); i++) begin
      word_req_t w;
      w = pool[p][i];
      if (w.last_word) w.kind = k;
      pending_words.push_back(w);
    end
  endtask

  initial begin
    word_req_t w;
    for (int b = 0; b < bbf_pkg::NumBlocks; b++) filter_bits[b] = '0;
    for (int i = 0; i < 4; i++) seed_pairs[i] = '0;
    in_key = 0;
    key_len = 0;
    hash_count = 3;
    block_count = 13'd4096;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, both operations, short and empty tails.
    w = '{kind: 0, key_word: 32'h0, word_bytes: 3'd4, last_word: 1};
    pending_words.push_back(w);
    w.kind = 1; pending_words.push_back(w);
    w = '{kind: 0, key_word: 32'hffffffff, word_bytes: 3'd7, last_word: 1};
    pending_words.push_back(w);
    w.kind = 1; pending_words.push_back(w);
    for (int nb = 0; nb <= 7; nb++) begin
      queue_key(0, 2, nb[2:0]);
      queue_key(1, 1, nb[2:0]);
    end
    w = '{kind: 1, key_word: 32'h12345678, word_bytes: 3'd1, last_word: 0};
    pending_words.push_back(w);
    w = '{kind: 1, key_word: 32'habcdef01, word_bytes: 3'd0, last_word: 1};
    pending_words.push_back(w);
    wait_drained(60);

    // Random phases through several register settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(bbf_pkg::RegNumHashes, 64'd0); write_reg(bbf_pkg::RegBlocks, 64'd1);
        end
        1: begin
          write_reg(bbf_pkg::RegNumHashes, 64'd7); write_reg(bbf_pkg::RegBlocks, 64'd0);
        end
        2: begin
          write_reg(bbf_pkg::RegNumHashes, 64'd1); write_reg(bbf_pkg::RegBlocks, 64'd8191);
        end
        3: begin
          write_reg(bbf_pkg::RegNumHashes, 64'd2); write_reg(bbf_pkg::RegBlocks, 64'd4096);
        end
        default: begin
          write_reg(bbf_pkg::RegNumHashes, 64'($urandom_range(7)));
          write_reg(bbf_pkg::RegBlocks, 64'($urandom_range(1, 8)));
        end
      endcase
      for (int s = 0; s < 4; s++)
        write_reg(bbf_pkg::RegSeed0 + 3'(s),
                  (ph == 1) ? 64'hffffffffffffffff : {$urandom, $urandom});
      idle_pct = (ph == 5) ? 0 : 35;
      for (int n = 0; n < 40; n++) begin
        if ($urandom_range(9) < 7) queue_pool_key($urandom_range(1));
        else queue_key($urandom_range(1), $urandom_range(1, 3), 3'($urandom_range(7)));
      end
      // Once every answer is in, let the sender pause, then queue more pool keys.
      if (ph == 3) begin
        wait_drained(0);
        hold_off = 1;
        repeat (20) @(posedge clk);
        hold_off = 0;
        for (int n = 0; n < 20; n++) queue_pool_key($urandom_range(1));
      end
      wait_drained(60);
    end

    $display("Covered %0d words over 9 register settings, %0d answers, %0d query hits.",
             keys_sent, answers_seen, queries_hit);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout: run did not drain");
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
